@@ hdl/oirc_pkg.sv @@
// Shared constants, result codes and control/status types for the origin identifier registry.
package oirc_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_BYTES_DEF    = 16;

  localparam int CAP_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 7;
  localparam int HALF_W      = 64;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Register index as decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

  typedef enum logic [STATUS_W-1:0] {
    ST_REGISTERED = 3'd0,
    ST_UNUSABLE   = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_MISSING    = 3'd3,
    ST_EXTERNAL   = 3'd4,
    ST_LOCAL      = 3'd5,
    ST_AMBIGUOUS  = 3'd6
  } status_t;

  typedef struct packed {
    logic load_item;
    logic dispatch;
    logic write_entry;
    logic scan_step;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reg_ok;
    logic classify_scan;
    logic scan_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ hdl/oirc_datapath.sv @@
// Datapath of the registry: item register, identifier memory, scan counter, matcher and output register.
module oirc_datapath #(
  parameter int TABLE_DEPTH = oirc_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BYTES    = oirc_pkg::ID_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  oirc_pkg::ctrl_cmd_t                  cmd,
  output oirc_pkg::ctrl_sts_t                  sts,
  input  logic [oirc_pkg::CAP_W-1:0]           capacity,
  input  logic                                 command,
  input  logic                                 origin_present,
  input  logic [oirc_pkg::HALF_W-1:0]          id_low,
  input  logic [oirc_pkg::HALF_W-1:0]          id_high,
  input  logic                                 result_stall,
  output logic                                 result_valid,
  output logic [oirc_pkg::STATUS_W-1:0]        status,
  output logic [oirc_pkg::COUNT_W-1:0]         match_count,
  output logic [oirc_pkg::COUNT_W-1:0]         entry_count
);
  import oirc_pkg::*;

  localparam int ID_BITS = ID_BYTES * 8;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [ID_BITS-1:0]  mem [TABLE_DEPTH];
  logic [ID_BITS-1:0]  rd_data;
  logic                rd_valid;

  logic                item_classify;
  logic                item_usable;
  logic [ID_BITS-1:0]  item_id;

  logic [CNT_W-1:0]    stored_count;
  logic [CNT_W-1:0]    match_cnt;
  logic [ADDR_W-1:0]   idx;
  status_t             res_status;

  logic [2*HALF_W-1:0] id_full;
  logic [ID_BITS-1:0]  id_masked;
  logic                can_store;
  logic                hit;
  status_t             final_status;

  assign id_full   = {id_high, id_low};
  assign id_masked = id_full[ID_BITS-1:0];

  assign can_store = (CMP_W'(stored_count) < CMP_W'(capacity))
                  && (stored_count < CNT_W'(TABLE_DEPTH));

  assign hit = rd_valid && (rd_data == item_id);

  assign sts.reg_ok        = !item_classify && item_usable && can_store;
  assign sts.classify_scan = item_classify && item_usable && (stored_count != '0);
  assign sts.scan_last     = CNT_W'(idx) == CNT_W'(stored_count - CNT_W'(1));
  assign sts.out_free      = !result_valid || !result_stall;

  always_comb begin
    final_status = res_status;
    if (item_classify && item_usable) begin
      if (match_cnt == '0) begin
        final_status = ST_EXTERNAL;
      end else if (match_cnt == CNT_W'(1)) begin
        final_status = ST_LOCAL;
      end else begin
        final_status = ST_AMBIGUOUS;
      end
    end
  end

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_classify <= command;
      item_usable   <= origin_present && (|id_masked);
      item_id       <= id_masked;
    end
  end

  // Identifier memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[stored_count[ADDR_W-1:0]] <= item_id;
    end
    if (cmd.scan_step) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      rd_valid     <= 1'b0;
      match_cnt    <= '0;
      idx          <= '0;
      res_status   <= ST_REGISTERED;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.write_entry) begin
        stored_count <= stored_count + CNT_W'(1);
      end
      if (cmd.dispatch) begin
        idx       <= '0;
        match_cnt <= '0;
        if (item_classify) begin
          res_status <= item_usable ? ST_EXTERNAL : ST_MISSING;
        end else if (!item_usable) begin
          res_status <= ST_UNUSABLE;
        end else if (!can_store) begin
          res_status <= ST_EXHAUSTED;
        end else begin
          res_status <= ST_REGISTERED;
        end
      end else begin
        if (cmd.scan_step) begin
          idx <= idx + ADDR_W'(1);
        end
        if (hit) begin
          match_cnt <= match_cnt + CNT_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status      <= final_status;
      match_count <= COUNT_W'(match_cnt);
      entry_count <= COUNT_W'(stored_count);
    end
  end

  a_write_in_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.write_entry |-> (stored_count < CNT_W'(TABLE_DEPTH)))
    else $error("entry written with the table full");

  a_matches_bounded: assert property (@(posedge clk) disable iff (rst)
    match_cnt <= stored_count)
    else $error("match count exceeds stored entries");

  a_read_follows_step: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |=> rd_valid)
    else $error("read data not flagged after a scan step");

endmodule

@@ hdl/oirc_controller.sv @@
// Controller state machine sequencing accept, dispatch, table scan and result hand-off.
module oirc_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  output oirc_pkg::ctrl_cmd_t cmd,
  input  oirc_pkg::ctrl_sts_t sts
);
  import oirc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_DRAIN    = 5'b01000,
    S_FIN      = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch    = 1'b1;
        cmd.write_entry = sts.reg_ok;
        state_next      = sts.classify_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_drain_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |=> (state == S_FIN))
    else $error("drain cycle not followed by result stage");

  a_fin_hands_off: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && sts.out_free) |=> (state == S_IDLE))
    else $error("result stage did not hand off with output free");

  a_scan_only_classify: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DISPATCH) && sts.reg_ok) |=> (state == S_FIN))
    else $error("registration entered the table scan");

endmodule

@@ hdl/origin_id_registry_classifier.sv @@
// Top level of the origin identifier registry and classifier with its APB capacity register.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------------
//  item      item_valid / item_stall   command, origin_present, id_low, id_high
//  result    result_valid / result_stall  status, match_count, entry_count
//  config    APB psel/penable/pwrite   paddr, pwdata -> capacity (address 0)
//
// A registration, an unusable identifier or a classification against an empty table
// passes from acceptance through the dispatch state to the result stage, which loads
// it into the result register. A classification of a usable identifier scans the
// stored entries through the single read port of the identifier memory, one entry a
// cycle, and then passes a drain state for the registered read before the result stage
// loads its result. One item is worked on at a time; a new item is accepted as soon as
// the previous result sits in the output register, even while that result is stalled,
// but a result still held there by a stall keeps the next result waiting in the
// controller's result stage. Reset clears the entry count, the capacity (to 64) and the
// control state; the identifier memory needs no clearing since only written entries
// are ever read.
module origin_id_registry_classifier #(
  parameter int TABLE_DEPTH = oirc_pkg::TABLE_DEPTH_DEF,
  parameter int ID_BYTES    = oirc_pkg::ID_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [oirc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [oirc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [oirc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                command,
  input  logic                                origin_present,
  input  logic [oirc_pkg::HALF_W-1:0]         id_low,
  input  logic [oirc_pkg::HALF_W-1:0]         id_high,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [oirc_pkg::STATUS_W-1:0]       status,
  output logic [oirc_pkg::COUNT_W-1:0]        match_count,
  output logic [oirc_pkg::COUNT_W-1:0]        entry_count
);
  import oirc_pkg::*;

  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;
  logic [CAP_W-1:0] capacity;
  logic             cfg_write;

  // The port never inserts wait states. Only bit 2 of the address selects a
  // register, so any write whose word index is zero lands on the capacity.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity) : '0;

  // The controller sequences each item; the datapath holds the table and the result.
  oirc_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  oirc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BYTES    (ID_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .capacity       (capacity),
    .command        (command),
    .origin_present (origin_present),
    .id_low         (id_low),
    .id_high        (id_high),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .status         (status),
    .match_count    (match_count),
    .entry_count    (entry_count)
  );

endmodule

@@ bench/origin_id_registry_classifier_test.sv @@
// Self-checking testbench for the origin identifier registry and classifier.
`timescale 1ns / 100ps

module origin_id_registry_classifier_test;
  import oirc_pkg::*;

  // Command codes of the item channel.
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // The capacity register sits at index zero.  The only other index that paddr can
  // reach is unused and must ignore writes.
  localparam logic [APB_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR    = {~REG_CAPACITY, 2'b00};

  // Only the low ID_BYTES bytes of an identifier take part in storage and comparison.
  localparam logic [127:0] ID_MASK = (ID_BYTES_DEF >= 16) ? {128{1'b1}} :
                                     ((128'd1 << (8 * ID_BYTES_DEF)) - 128'd1);

  // Covers a full table scan and the states around it, with some margin.
  localparam int SETTLE_CYCLES  = TABLE_DEPTH_DEF + 8;
  // Cycles without any handshake before the run is declared hung.  The slowest item
  // needs a scan of the whole table, the longest sender gap and the longest stall.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    status_t              code;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   stored;
  } verdict_t;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   psel           = 1'b0;
  logic                   penable        = 1'b0;
  logic                   pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr          = '0;
  logic [APB_DATA_W-1:0]  pwdata         = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   item_valid     = 1'b0;
  logic                   item_stall;
  logic                   command        = CMD_REGISTER;
  logic                   origin_present = 1'b0;
  logic [HALF_W-1:0]      id_low         = '0;
  logic [HALF_W-1:0]      id_high        = '0;
  logic                   result_valid;
  logic                   result_stall   = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_W-1:0]     match_count;
  logic [COUNT_W-1:0]     entry_count;

  // Our own copy of the registry: the stored identifiers, how many there are and the
  // capacity as last written.
  logic [127:0]           known_ids [TABLE_DEPTH_DEF];
  int                     known_count = 0;
  logic [CAP_W-1:0]       cap_setting = CAPACITY_RESET;

  verdict_t               awaited_results [$];
  int                     fault_count = 0;

  // Idling profile, changed from test to test: the longest gap the sender leaves
  // before an item and the longest stall the receiver applies to a result.
  int                     gap_max   = 0;
  int                     stall_max = 0;
  int                     stall_left = 0;
  int                     quiet_cycles = 0;

  origin_id_registry_classifier uut (.*);

  always #4 clk = ~clk;

  // Works out the result of one accepted item and advances the registry copy.
  // A registration is checked for a usable identifier first, so an unusable item
  // against a full table still reports unusable.  The effective limit never exceeds
  // the table depth, and lowering the capacity never removes stored entries.
  function automatic verdict_t predict_outcome(logic cmd, logic present,
                                               logic [HALF_W-1:0] lo,
                                               logic [HALF_W-1:0] hi);
    verdict_t     outcome;
    logic [127:0] ident;
    logic         usable;
    int           limit_now;
    int           hits;
    ident     = {hi, lo} & ID_MASK;
    usable    = present && (ident != '0);
    limit_now = (cap_setting > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(cap_setting);
    hits      = 0;
    if (cmd == CMD_REGISTER) begin
      if (!usable) begin
        outcome.code = ST_UNUSABLE;
      end else if (known_count >= limit_now) begin
        outcome.code = ST_EXHAUSTED;
      end else begin
        known_ids[known_count] = ident;
        known_count++;
        outcome.code = ST_REGISTERED;
      end
    end else if (!usable) begin
      outcome.code = ST_MISSING;
    end else begin
      for (int i = 0; i < known_count; i++) begin
        if (known_ids[i] == ident) hits++;
      end
      if (hits == 0) outcome.code = ST_EXTERNAL;
      else if (hits == 1) outcome.code = ST_LOCAL;
      else outcome.code = ST_AMBIGUOUS;
    end
    outcome.hits   = hits[COUNT_W-1:0];
    outcome.stored = known_count[COUNT_W-1:0];
    return outcome;
  endfunction

  // Offers one item after a random gap and holds it until it is accepted.  Every
  // call starts and ends just after a rising edge; valid stays high when the next
  // item follows without a gap, so it is never lowered and raised in the same step.
  task automatic send_item(logic cmd, logic present, logic [HALF_W-1:0] lo,
                           logic [HALF_W-1:0] hi);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    command        <= cmd;
    origin_present <= present;
    id_low         <= lo;
    id_high        <= hi;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    awaited_results.insert(awaited_results.size(), predict_outcome(cmd, present, lo, hi));
  endtask

  // Lets the block run dry: every awaited result arrives, then the bench idles on
  // so that nothing is still in flight.
  task automatic settle_block();
    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each access lets the port go idle again before it ends, so that back-to-back accesses
  // never assign the port signals twice in one step.
  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[2] == REG_CAPACITY) cap_setting = data[CAP_W-1:0];
    @(posedge clk);
  endtask

  task automatic apb_read(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Picks a random item.  Almost half of the identifiers are drawn from those already
  // stored, so that classifications find local and ambiguous matches and registrations
  // store duplicates; the rest are fresh, half zero, or unusable.
  task automatic draw_item(output logic cmd, output logic present,
                           output logic [HALF_W-1:0] lo, output logic [HALF_W-1:0] hi);
    int roll;
    roll    = $urandom_range(0, 99);
    cmd     = ($urandom_range(0, 99) < 40) ? CMD_REGISTER : CMD_CLASSIFY;
    present = 1'b1;
    lo      = {$urandom, $urandom};
    hi      = {$urandom, $urandom};
    if (roll < 10) begin
      if ($urandom_range(0, 1)) begin
        present = 1'b0;
      end else begin
        lo = '0;
        hi = '0;
      end
    end else if (roll < 55 && known_count > 0) begin
      {hi, lo} = known_ids[$urandom_range(0, known_count - 1)];
    end else if (roll < 65) begin
      if ($urandom_range(0, 1)) lo = '0;
      else hi = '0;
    end
  endtask

  // With nothing stored, every usable classification is external and every unusable
  // item is refused, whichever way it is unusable.
  task automatic test_empty_table();
    send_item(CMD_CLASSIFY, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(CMD_CLASSIFY, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(CMD_CLASSIFY, 1'b1, '0, '0);
    send_item(CMD_REGISTER, 1'b0, '1, '1);
    send_item(CMD_REGISTER, 1'b1, '0, '0);
  endtask

  // Registrations at the extremes of the identifier, a duplicate, and classification
  // of each stored value as well as of near misses.
  task automatic test_registration();
    send_item(CMD_REGISTER, 1'b1, '1, '1);
    send_item(CMD_REGISTER, 1'b1, 64'd1, '0);
    send_item(CMD_REGISTER, 1'b1, '0, {1'b1, 63'd0});
    send_item(CMD_REGISTER, 1'b1, '1, '1);
    send_item(CMD_CLASSIFY, 1'b1, '1, '1);
    send_item(CMD_CLASSIFY, 1'b1, 64'd1, '0);
    send_item(CMD_CLASSIFY, 1'b1, '0, {1'b1, 63'd0});
    send_item(CMD_CLASSIFY, 1'b0, '1, '1);
    send_item(CMD_CLASSIFY, 1'b1, '1, {1'b0, {63{1'b1}}});
    send_item(CMD_CLASSIFY, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Capacity zero, a capacity with junk above its field, a capacity below the
  // stored count, a write to the unused index, a read back, and the extremes.
  task automatic test_capacity_limits();
    logic [APB_DATA_W-1:0] readback;
    settle_block();
    apb_write(CAPACITY_ADDR, '0);
    send_item(CMD_REGISTER, 1'b1, 64'hA5A5_0000_0000_5A5A, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_REGISTER, 1'b1, '0, '0);
    settle_block();
    apb_write(CAPACITY_ADDR, 32'hFFFF_FF80 | 32'(known_count + 1));
    send_item(CMD_REGISTER, 1'b1, 64'hA5A5_0000_0000_5A5A, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_REGISTER, 1'b1, 64'h0000_0000_0000_0002, '0);
    settle_block();
    apb_write(CAPACITY_ADDR, 32'd1);
    send_item(CMD_REGISTER, 1'b1, 64'h0000_0000_0000_0002, '0);
    send_item(CMD_CLASSIFY, 1'b1, 64'hA5A5_0000_0000_5A5A, 64'h0123_4567_89AB_CDEF);
    settle_block();
    apb_write(SPARE_ADDR, 32'd64);
    send_item(CMD_REGISTER, 1'b1, 64'h0000_0000_0000_0002, '0);
    settle_block();
    apb_read(CAPACITY_ADDR, readback);
    if (readback !== APB_DATA_W'(cap_setting)) begin
      $error("capacity readback: expected %0d, got %0d", cap_setting, readback);
      fault_count++;
    end
    apb_write(CAPACITY_ADDR, 32'd127);
    apb_write(CAPACITY_ADDR, 32'(TABLE_DEPTH_DEF));
  endtask

  // Ten phases of a hundred items, each with its own capacity and idling profile.
  // The capacity often lets the table grow by one to six entries per phase, so that
  // refusals for exhaustion come up throughout; the last two phases open it fully
  // and fill the table to its depth.
  task automatic test_random_traffic();
    logic              cmd;
    logic              present;
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    int                cap;
    for (int phase = 0; phase < 10; phase++) begin
      settle_block();
      case ($urandom_range(0, 4))
        0:       cap = 0;
        1:       cap = 1;
        2:       cap = known_count;
        default: cap = known_count + $urandom_range(1, 6);
      endcase
      if (phase == 8) cap = TABLE_DEPTH_DEF;
      if (phase == 9) cap = 127;
      apb_write(CAPACITY_ADDR, 32'(cap));
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = $urandom_range(1, 13);
        default: gap_max = 13;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_max = 0;
        1:       stall_max = $urandom_range(1, 13);
        default: stall_max = 13;
      endcase
      // One phase runs flat out on both sides.
      if (phase == 1) begin
        gap_max   = 0;
        stall_max = 0;
      end
      for (int n = 0; n < 100; n++) begin
        draw_item(cmd, present, lo, hi);
        send_item(cmd, present, lo, hi);
      end
    end
  endtask

  // The receiver draws a stall length for every result and counts it down only
  // while a result is on offer.
  always @(posedge clk) begin
    if (result_valid && !result_stall) stall_left = $urandom_range(0, stall_max);
    else if (result_valid && stall_left > 0) stall_left = stall_left - 1;
    result_stall <= (stall_left != 0);
  end

  // Each accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin : check_results
    verdict_t due;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d, match_count %0d, entry_count %0d",
               status, match_count, entry_count);
        fault_count++;
      end else begin
        due = awaited_results.pop_front();
        if (status !== due.code) begin
          $error("status: expected %0d, got %0d", due.code, status);
          fault_count++;
        end
        if (match_count !== due.hits) begin
          $error("match_count: expected %0d, got %0d", due.hits, match_count);
          fault_count++;
        end
        if (entry_count !== due.stored) begin
          $error("entry_count: expected %0d, got %0d", due.stored, entry_count);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: any handshake on either channel or an access on the register port
  // counts as progress.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    gap_max   = 3;
    stall_max = 3;
    test_empty_table();
    test_registration();
    test_capacity_limits();
    test_random_traffic();
    settle_block();
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
